// ===== rtl/core/rtc_pkg.sv =====
// shared widths, types and defaults for the running truncated convolution
package rtc_pkg;

  localparam int unsigned ValueW  = 24;
  localparam int unsigned ProdW   = 2 * ValueW;
  localparam int unsigned SumW    = 64;
  localparam int unsigned PosW    = 10;
  localparam int unsigned MaxLenDefault = 1024;

  typedef logic signed [ValueW-1:0] value_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [SumW-1:0]   sum_t;
  typedef logic [PosW-1:0]          pos_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

endpackage

// ===== rtl/core/rtc_if.sv =====
// input and output channel interfaces
interface rtc_in_if;
  import rtc_pkg::*;
  logic   valid;
  logic   ready;
  value_t first_value;
  value_t second_value;
  logic   start_sequence;
  modport source(output valid, first_value, second_value, start_sequence, input ready);
  modport sink(input valid, first_value, second_value, start_sequence, output ready);
endinterface

interface rtc_out_if;
  import rtc_pkg::*;
  logic valid;
  logic ready;
  sum_t sum_value;
  pos_t position;
  logic overflow;
  modport source(output valid, sum_value, position, overflow, input ready);
  modport sink(input valid, sum_value, position, overflow, output ready);
endinterface

// ===== rtl/core/rtc_ram.sv =====
// generic simple dual-port ram with registered read
module rtc_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/running_truncated_convolution.sv =====
// running truncated convolution top level with one shared multiply-accumulate unit
// Each accepted beat stores element i of both sequences in two history rams and then
// runs one multiply-accumulate per stored pair through a single 24x24 multiplier,
// reading a_k and b_(i-k) each cycle; each term is issued to the rams and then passes
// through the ram read, product and accumulate stages, and the result is loaded once
// the last term has drained. A beat that finds the history full without a start flag
// returns overflow with zero sum and zero position.
// The input is taken only while the unit is idle; a finished result waits in the output
// register while the next beat is accepted. No clearing pass is needed after reset.
module running_truncated_convolution #(
  parameter int unsigned MaxLen = rtc_pkg::MaxLenDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  rtc_in_if.sink    in_i,
  rtc_out_if.source out_o
);
  import rtc_pkg::*;

  localparam int unsigned AddrW  = $clog2(MaxLen);
  localparam int unsigned CountW = $clog2(MaxLen + 1);
  localparam int unsigned PosBits = (AddrW < PosW) ? AddrW : PosW;

  state_e state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  logic [AddrW-1:0]  idx_q, idx_d;
  logic [AddrW-1:0]  k_q, k_d;
  logic [AddrW-1:0]  j_q, j_d;
  logic              ovf_q, ovf_d;
  logic              v1_q, v2_q;
  prod_t             prod_q;
  sum_t              acc_q, acc_d;
  logic              out_valid_q, out_valid_d;
  sum_t              out_sum_q, out_sum_d;
  pos_t              out_pos_q, out_pos_d;
  logic              out_ovf_q, out_ovf_d;

  logic              accept;
  logic [CountW-1:0] eff_count;
  logic              full;
  logic              issue;
  logic [AddrW-1:0]  wr_addr;
  value_t            rd_a, rd_b;
  pos_t              pos_ext;
  logic              load_out;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign eff_count  = in_i.start_sequence ? '0 : count_q;
  assign full       = (eff_count == CountW'(MaxLen));
  assign wr_addr    = eff_count[AddrW-1:0];
  assign issue      = (state_q == S_RUN);

  rtc_ram #(.Width(ValueW), .Depth(MaxLen)) u_first_ram (
    .clk_i  (clk_i),
    .we_i   (accept && !full),
    .waddr_i(wr_addr),
    .wdata_i(in_i.first_value),
    .raddr_i(k_q),
    .rdata_o(rd_a)
  );

  rtc_ram #(.Width(ValueW), .Depth(MaxLen)) u_second_ram (
    .clk_i  (clk_i),
    .we_i   (accept && !full),
    .waddr_i(wr_addr),
    .wdata_i(in_i.second_value),
    .raddr_i(j_q),
    .rdata_o(rd_b)
  );

  always_comb begin
    pos_ext = '0;
    for (int unsigned b = 0; b < PosBits; b++) begin
      pos_ext[b] = idx_q[b];
    end
  end

  assign load_out = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    k_d         = k_q;
    j_d         = j_q;
    ovf_d       = ovf_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    out_sum_d   = out_sum_q;
    out_pos_d   = out_pos_q;
    out_ovf_d   = out_ovf_q;

    if (v2_q) begin
      acc_d = acc_q + {{(SumW - ProdW){prod_q[ProdW-1]}}, prod_q};
    end
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          acc_d = '0;
          k_d   = '0;
          j_d   = wr_addr;
          idx_d = wr_addr;
          if (full) begin
            count_d = eff_count;
            ovf_d   = 1'b1;
            state_d = S_DONE;
          end else begin
            count_d = eff_count + 1'b1;
            ovf_d   = 1'b0;
            state_d = S_RUN;
          end
        end
      end
      S_RUN: begin
        k_d = k_q + 1'b1;
        j_d = j_q - 1'b1;
        if (k_q == idx_q) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!v1_q && !v2_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          out_sum_d   = ovf_q ? '0 : acc_q;
          out_pos_d   = ovf_q ? '0 : pos_ext;
          out_ovf_d   = ovf_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      v1_q        <= issue;
      v2_q        <= v1_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    k_q       <= k_d;
    j_q       <= j_d;
    ovf_q     <= ovf_d;
    acc_q     <= acc_d;
    prod_q    <= rd_a * rd_b;
    out_sum_q <= out_sum_d;
    out_pos_q <= out_pos_d;
    out_ovf_q <= out_ovf_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.sum_value = out_sum_q;
  assign out_o.position  = out_pos_q;
  assign out_o.overflow  = out_ovf_q;

endmodule
